### design/dsab_pkg.sv
// ----------------------------------------------------------------------------
// dsab_pkg: shared types and codes for the DNA suffix array builder
// Command codes, controller micro-op codes and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dsab_pkg;

    // input word command codes
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_BUILD  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // result word kinds
    localparam logic KIND_BUILD = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // micro-op codes; the controller state uses the same codes
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP    = 5'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 5'd1;
    localparam logic [OP_W-1:0] OP_RDBAD  = 5'd2;
    localparam logic [OP_W-1:0] OP_RDREQ  = 5'd3;
    localparam logic [OP_W-1:0] OP_RDOUT  = 5'd4;
    localparam logic [OP_W-1:0] OP_BSTART = 5'd5;
    localparam logic [OP_W-1:0] OP_CLR    = 5'd6;
    localparam logic [OP_W-1:0] OP_HREAD  = 5'd7;
    localparam logic [OP_W-1:0] OP_HCNT   = 5'd8;
    localparam logic [OP_W-1:0] OP_HWR    = 5'd9;
    localparam logic [OP_W-1:0] OP_PREAD  = 5'd10;
    localparam logic [OP_W-1:0] OP_PWR    = 5'd11;
    localparam logic [OP_W-1:0] OP_SSREAD = 5'd12;
    localparam logic [OP_W-1:0] OP_SSCNT  = 5'd13;
    localparam logic [OP_W-1:0] OP_SSWR   = 5'd14;
    localparam logic [OP_W-1:0] OP_CREAD  = 5'd15;
    localparam logic [OP_W-1:0] OP_CSYM   = 5'd16;
    localparam logic [OP_W-1:0] OP_CWR    = 5'd17;
    localparam logic [OP_W-1:0] OP_DREAD  = 5'd18;
    localparam logic [OP_W-1:0] OP_DCLS   = 5'd19;
    localparam logic [OP_W-1:0] OP_DCNT   = 5'd20;
    localparam logic [OP_W-1:0] OP_DWR    = 5'd21;
    localparam logic [OP_W-1:0] OP_KREAD  = 5'd22;
    localparam logic [OP_W-1:0] OP_KWR    = 5'd23;
    localparam logic [OP_W-1:0] OP_UREAD  = 5'd24;
    localparam logic [OP_W-1:0] OP_UC     = 5'd25;
    localparam logic [OP_W-1:0] OP_UMC    = 5'd26;
    localparam logic [OP_W-1:0] OP_UWR    = 5'd27;
    localparam logic [OP_W-1:0] OP_LREAD  = 5'd28;
    localparam logic [OP_W-1:0] OP_LWR    = 5'd29;
    localparam logic [OP_W-1:0] OP_DOUBLE = 5'd30;
    localparam logic [OP_W-1:0] OP_BDONE  = 5'd31;

    // loop counter control
    localparam logic [1:0] CTR_STEP = 2'd0;
    localparam logic [1:0] CTR_ZERO = 2'd1;
    localparam logic [1:0] CTR_TOP  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      ctr;
    } dsab_cmd_t;

    typedef struct packed {
        logic r_last;    // counter at last bucket of the count range
        logic n_last;    // counter at last text position
        logic i_zero;    // counter at zero
        logic len_done;  // compared length already covers the text
        logic dbl_done;  // doubled length will cover the text
        logic rd_bad;    // read index out of range or nothing built
        logic sym_mode;  // sorting single symbols, not class pairs
        logic out_busy;  // result word waiting
    } dsab_status_t;

endpackage

### design/dsab_ram.sv
// ----------------------------------------------------------------------------
// dsab_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dsab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/dsab_ctrl.sv
// ----------------------------------------------------------------------------
// dsab_ctrl: sequencer of the suffix array builder
// Steps through counting sort, class assignment and doubling rounds,
// issuing one micro-op per cycle to the datapath.
// ----------------------------------------------------------------------------
module dsab_ctrl
    import dsab_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic [1:0]   command,
    input  dsab_status_t st,
    output logic         in_stall,
    output dsab_cmd_t    cmd
);

    logic [OP_W-1:0] state_reg;
    logic [OP_W-1:0] state_next;
    logic            accept;

    assign in_stall = (state_reg != OP_NOP) || st.out_busy;
    assign accept   = in_valid && !in_stall;

    // next state and micro-op
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = state_reg;
        cmd.ctr    = CTR_STEP;
        case (state_reg)
            OP_NOP:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_APPEND: cmd.op = OP_APPEND;
                        CMD_BUILD:  state_next = OP_BSTART;
                        CMD_READ:
                        begin
                            if (st.rd_bad)
                            begin
                                cmd.op = OP_RDBAD;
                            end
                            else
                            begin
                                cmd.op     = OP_RDREQ;
                                state_next = OP_RDOUT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_RDOUT:  state_next = OP_NOP;
            OP_BSTART:
            begin
                cmd.ctr    = CTR_ZERO;
                state_next = OP_CLR;
            end
            // clear bucket counts
            OP_CLR:
            begin
                if (st.r_last)
                begin
                    cmd.ctr    = CTR_ZERO;
                    state_next = OP_HREAD;
                end
            end
            // histogram
            OP_HREAD:  state_next = OP_HCNT;
            OP_HCNT:   state_next = OP_HWR;
            OP_HWR:
            begin
                if (st.n_last)
                begin
                    cmd.ctr    = CTR_ZERO;
                    state_next = OP_PREAD;
                end
                else
                begin
                    state_next = OP_HREAD;
                end
            end
            // prefix sums
            OP_PREAD:  state_next = OP_PWR;
            OP_PWR:
            begin
                if (st.r_last)
                begin
                    cmd.ctr    = CTR_TOP;
                    state_next = st.sym_mode ? OP_SSREAD : OP_DREAD;
                end
                else
                begin
                    state_next = OP_PREAD;
                end
            end
            // symbol scatter
            OP_SSREAD: state_next = OP_SSCNT;
            OP_SSCNT:  state_next = OP_SSWR;
            OP_SSWR:
            begin
                if (st.i_zero)
                begin
                    cmd.ctr    = CTR_ZERO;
                    state_next = OP_CREAD;
                end
                else
                begin
                    state_next = OP_SSREAD;
                end
            end
            // symbol classes
            OP_CREAD:  state_next = OP_CSYM;
            OP_CSYM:   state_next = OP_CWR;
            OP_CWR:
            begin
                if (st.n_last)
                begin
                    cmd.ctr = CTR_ZERO;
                    state_next = st.len_done ? OP_BDONE : OP_CLR;
                end
                else
                begin
                    state_next = OP_CREAD;
                end
            end
            // shifted scatter
            OP_DREAD:  state_next = OP_DCLS;
            OP_DCLS:   state_next = OP_DCNT;
            OP_DCNT:   state_next = OP_DWR;
            OP_DWR:
            begin
                if (st.i_zero)
                begin
                    cmd.ctr    = CTR_ZERO;
                    state_next = OP_KREAD;
                end
                else
                begin
                    state_next = OP_DREAD;
                end
            end
            // copy order back
            OP_KREAD:  state_next = OP_KWR;
            OP_KWR:
            begin
                if (st.n_last)
                begin
                    cmd.ctr    = CTR_ZERO;
                    state_next = OP_UREAD;
                end
                else
                begin
                    state_next = OP_KREAD;
                end
            end
            // class update
            OP_UREAD:  state_next = OP_UC;
            OP_UC:     state_next = OP_UMC;
            OP_UMC:    state_next = OP_UWR;
            OP_UWR:
            begin
                if (st.n_last)
                begin
                    cmd.ctr    = CTR_ZERO;
                    state_next = OP_LREAD;
                end
                else
                begin
                    state_next = OP_UREAD;
                end
            end
            // copy classes back
            OP_LREAD:  state_next = OP_LWR;
            OP_LWR:
            begin
                state_next = st.n_last ? OP_DOUBLE : OP_LREAD;
            end
            OP_DOUBLE:
            begin
                cmd.ctr    = CTR_ZERO;
                state_next = st.dbl_done ? OP_BDONE : OP_CLR;
            end
            OP_BDONE:  state_next = OP_NOP;
            default:   state_next = OP_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= OP_NOP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/dsab_dp.sv
// ----------------------------------------------------------------------------
// dsab_dp: datapath of the suffix array builder
// Text, order, class and bucket memories, loop counter, length registers
// and the result word register.
// ----------------------------------------------------------------------------
module dsab_dp
    import dsab_pkg::*;
#(
    parameter int MAX_LEN       = 1024,
    parameter int ALPHABET_SIZE = 5
) (
    input  logic         clk,
    input  logic         rst_n,
    input  dsab_cmd_t    cmd,
    output dsab_status_t st,
    input  logic [1:0]   base,
    input  logic [9:0]   index,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         kind,
    output logic [10:0]  value,
    output logic         error
);

    localparam int AW  = $clog2(MAX_LEN);
    localparam int CW  = AW + 1;
    localparam int LW  = AW + 2;
    localparam int CD  = (MAX_LEN > ALPHABET_SIZE) ? MAX_LEN : ALPHABET_SIZE;
    localparam int CAW = $clog2(CD);
    localparam int XW  = ((CAW > AW) ? CAW : AW) + 1;

    // control registers
    logic [CW-1:0] text_len_reg, text_len_next;
    logic [CW-1:0] n_reg, n_next;
    logic [LW-1:0] len_reg, len_next;
    logic [XW-1:0] i_reg, i_next;
    logic          sym_mode_reg, sym_mode_next;
    logic          built_reg, built_next;
    logic          dropped_reg, dropped_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [CW-1:0]  acc_reg;
    logic [CAW-1:0] key_reg;
    logic [AW-1:0]  c_reg, start_reg, mc_reg, cc_reg, pc_reg, pmc_reg, prev_cls_reg;
    logic [CAW-1:0] prev_bk_reg;
    logic           out_kind_reg;
    logic [10:0]    out_value_reg;
    logic           out_error_reg;

    // memory ports
    logic          sym_we, sa_we, sa2_we, cls_we, cls2_we, cnt_we;
    logic [AW-1:0] sym_wa, sym_ra, sa_wa, sa_ra, sa2_wa, sa2_ra;
    logic [AW-1:0] cls_wa, cls_ra, cls2_wa, cls2_ra;
    logic [CAW-1:0] cnt_wa, cnt_ra;
    logic [2:0]    sym_wd, sym_rd;
    logic [AW-1:0] sa_wd, sa_rd, sa2_wd, sa2_rd, cls_wd, cls_rd, cls2_wd, cls2_rd;
    logic [CW-1:0] cnt_wd, cnt_rd;

    // derived values
    logic [AW-1:0]  i_a;
    logic [CAW-1:0] i_c;
    logic [CAW-1:0] bk;
    logic [CW-1:0]  eff_len;
    logic [LW-1:0]  start_calc, mc_sum, mc_calc;
    logic [AW-1:0]  cwr_val, uwr_val;
    logic           ctr_up, ctr_dn;

    assign i_a = AW'(i_reg);
    assign i_c = CAW'(i_reg);
    assign bk  = (32'(sym_rd) < ALPHABET_SIZE) ? CAW'(sym_rd) : CAW'(ALPHABET_SIZE - 1);
    assign eff_len = built_reg ? '0 : text_len_reg;

    // shifted start, wrapped around the text
    assign start_calc = (LW'(sa_rd) >= len_reg) ? (LW'(sa_rd) - len_reg)
                                                : (LW'(sa_rd) + LW'(n_reg) - len_reg);
    assign mc_sum  = LW'(sa_rd) + len_reg;
    assign mc_calc = (mc_sum >= LW'(n_reg)) ? (mc_sum - LW'(n_reg)) : mc_sum;

    // new class values
    assign cwr_val = st.i_zero ? '0 : (prev_cls_reg + AW'(bk != prev_bk_reg));
    assign uwr_val = st.i_zero ? '0
                   : (prev_cls_reg + AW'((cc_reg != pc_reg) || (cls_rd != pmc_reg)));

    // status to controller
    always_comb
    begin
        st.n_last   = (i_reg == (XW'(n_reg) - XW'(1)));
        st.r_last   = sym_mode_reg ? (i_reg == XW'(ALPHABET_SIZE - 1)) : st.n_last;
        st.i_zero   = (i_reg == '0);
        st.len_done = (len_reg >= LW'(n_reg));
        st.dbl_done = ((len_reg << 1) >= LW'(n_reg));
        st.rd_bad   = !built_reg || (32'(index) >= 32'(n_reg));
        st.sym_mode = sym_mode_reg;
        st.out_busy = out_valid_reg;
    end

    // memory port selection
    always_comb
    begin
        sym_we = 1'b0; sym_wa = AW'(eff_len); sym_wd = 3'(base) + 3'd1; sym_ra = i_a;
        sa_we  = 1'b0; sa_wa  = AW'(cnt_rd - CW'(1)); sa_wd = i_a; sa_ra = i_a;
        sa2_we = 1'b0; sa2_wa = AW'(cnt_rd - CW'(1)); sa2_wd = start_reg; sa2_ra = i_a;
        cls_we = 1'b0; cls_wa = c_reg; cls_wd = cwr_val; cls_ra = i_a;
        cls2_we = 1'b0; cls2_wa = c_reg; cls2_wd = uwr_val; cls2_ra = i_a;
        cnt_we = 1'b0; cnt_wa = key_reg; cnt_wd = cnt_rd - CW'(1); cnt_ra = i_c;
        case (cmd.op)
            OP_APPEND: sym_we = (eff_len < CW'(MAX_LEN - 1));
            OP_BSTART:
            begin
                sym_we = 1'b1;
                sym_wa = AW'(text_len_reg);
                sym_wd = 3'd0;
            end
            OP_RDREQ:  sa_ra = AW'(index);
            OP_CLR:
            begin
                cnt_we = 1'b1;
                cnt_wa = i_c;
                cnt_wd = '0;
            end
            OP_HCNT:   cnt_ra = sym_mode_reg ? bk : CAW'(cls_rd);
            OP_HWR:
            begin
                cnt_we = 1'b1;
                cnt_wd = cnt_rd + CW'(1);
            end
            OP_PWR:
            begin
                cnt_we = 1'b1;
                cnt_wa = i_c;
                cnt_wd = acc_reg + cnt_rd;
            end
            OP_SSCNT:  cnt_ra = bk;
            OP_SSWR:
            begin
                cnt_we = 1'b1;
                sa_we  = 1'b1;
            end
            OP_CSYM:   sym_ra = AW'(sa_rd);
            OP_CWR:    cls_we = 1'b1;
            OP_DCLS:   cls_ra = AW'(start_calc);
            OP_DCNT:   cnt_ra = CAW'(cls_rd);
            OP_DWR:
            begin
                cnt_we = 1'b1;
                sa2_we = 1'b1;
            end
            OP_KWR:
            begin
                sa_we = 1'b1;
                sa_wa = i_a;
                sa_wd = sa2_rd;
            end
            OP_UC:     cls_ra = AW'(sa_rd);
            OP_UMC:    cls_ra = mc_reg;
            OP_UWR:    cls2_we = 1'b1;
            OP_LWR:
            begin
                cls_we = 1'b1;
                cls_wa = i_a;
                cls_wd = cls2_rd;
            end
            default: ;
        endcase
    end

    // control register next values
    always_comb
    begin
        text_len_next  = text_len_reg;
        n_next         = n_reg;
        len_next       = len_reg;
        sym_mode_next  = sym_mode_reg;
        built_next     = built_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg && out_stall;
        ctr_up = 1'b0;
        ctr_dn = 1'b0;
        case (cmd.op)
            OP_APPEND:
            begin
                built_next = 1'b0;
                if (eff_len < CW'(MAX_LEN - 1))
                begin
                    text_len_next = eff_len + CW'(1);
                    dropped_next  = built_reg ? 1'b0 : dropped_reg;
                end
                else
                begin
                    text_len_next = eff_len;
                    dropped_next  = 1'b1;
                end
            end
            OP_RDBAD, OP_RDOUT: out_valid_next = 1'b1;
            OP_BSTART:
            begin
                n_next        = text_len_reg + CW'(1);
                len_next      = LW'(1);
                sym_mode_next = 1'b1;
            end
            OP_CLR, OP_HWR, OP_PWR, OP_KWR, OP_UWR, OP_LWR: ctr_up = 1'b1;
            OP_SSWR, OP_DWR: ctr_dn = 1'b1;
            OP_CWR:
            begin
                ctr_up = 1'b1;
                if (st.n_last)
                begin
                    sym_mode_next = 1'b0;
                end
            end
            OP_DOUBLE: len_next = len_reg << 1;
            OP_BDONE:
            begin
                built_next     = 1'b1;
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
        case (cmd.ctr)
            CTR_ZERO: i_next = '0;
            CTR_TOP:  i_next = XW'(n_reg) - XW'(1);
            default:
            begin
                if (ctr_up)
                begin
                    i_next = i_reg + XW'(1);
                end
                else if (ctr_dn)
                begin
                    i_next = i_reg - XW'(1);
                end
                else
                begin
                    i_next = i_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_len_reg  <= '0;
            n_reg         <= CW'(1);
            len_reg       <= LW'(1);
            i_reg         <= '0;
            sym_mode_reg  <= 1'b0;
            built_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            text_len_reg  <= text_len_next;
            n_reg         <= n_next;
            len_reg       <= len_next;
            i_reg         <= i_next;
            sym_mode_reg  <= sym_mode_next;
            built_reg     <= built_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CLR:   acc_reg <= '0;
            OP_PWR:   acc_reg <= acc_reg + cnt_rd;
            OP_HCNT:  key_reg <= sym_mode_reg ? bk : CAW'(cls_rd);
            OP_SSCNT: key_reg <= bk;
            OP_DCNT:  key_reg <= CAW'(cls_rd);
            OP_CSYM:  c_reg <= AW'(sa_rd);
            OP_CWR:
            begin
                prev_cls_reg <= cwr_val;
                prev_bk_reg  <= bk;
            end
            OP_DCLS:  start_reg <= AW'(start_calc);
            OP_UC:
            begin
                c_reg  <= AW'(sa_rd);
                mc_reg <= AW'(mc_calc);
            end
            OP_UMC:   cc_reg <= cls_rd;
            OP_UWR:
            begin
                pc_reg       <= cc_reg;
                pmc_reg      <= cls_rd;
                prev_cls_reg <= uwr_val;
            end
            OP_RDBAD:
            begin
                out_kind_reg  <= KIND_READ;
                out_value_reg <= '0;
                out_error_reg <= 1'b1;
            end
            OP_RDOUT:
            begin
                out_kind_reg  <= KIND_READ;
                out_value_reg <= 11'(sa_rd);
                out_error_reg <= 1'b0;
            end
            OP_BDONE:
            begin
                out_kind_reg  <= KIND_BUILD;
                out_value_reg <= 11'(n_reg);
                out_error_reg <= dropped_reg;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign value     = out_value_reg;
    assign error     = out_error_reg;

    // memories
    dsab_ram #(.WIDTH(3), .DEPTH(MAX_LEN)) u_sym (
        .clk(clk), .we(sym_we), .waddr(sym_wa), .wdata(sym_wd),
        .raddr(sym_ra), .rdata(sym_rd)
    );
    dsab_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_sa (
        .clk(clk), .we(sa_we), .waddr(sa_wa), .wdata(sa_wd),
        .raddr(sa_ra), .rdata(sa_rd)
    );
    dsab_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_sa2 (
        .clk(clk), .we(sa2_we), .waddr(sa2_wa), .wdata(sa2_wd),
        .raddr(sa2_ra), .rdata(sa2_rd)
    );
    dsab_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_cls (
        .clk(clk), .we(cls_we), .waddr(cls_wa), .wdata(cls_wd),
        .raddr(cls_ra), .rdata(cls_rd)
    );
    dsab_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_cls2 (
        .clk(clk), .we(cls2_we), .waddr(cls2_wa), .wdata(cls2_wd),
        .raddr(cls2_ra), .rdata(cls2_rd)
    );
    dsab_ram #(.WIDTH(CW), .DEPTH(CD)) u_cnt (
        .clk(clk), .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
        .raddr(cnt_ra), .rdata(cnt_rd)
    );

endmodule

### design/dna_suffix_array_builder.sv
// ----------------------------------------------------------------------------
// dna_suffix_array_builder: suffix array builder for DNA text
// Prefix doubling with counting sort over single-port-per-direction RAMs.
// ----------------------------------------------------------------------------
// Usage: append bases one word at a time, issue a build, then read suffix
// array entries by rank. A read issues the order memory request and then
// registers the result word (an out-of-range read gives an error word with
// no memory read); one word is in flight at a time and a waiting result
// holds off the next word. A build covers n symbols (bases plus the
// sentinel); each RAM serves one read and one write per cycle, so the
// histogram, prefix, scatter, class and copy sweeps each walk the text
// element by element. An append after a build starts a new text.
module dna_suffix_array_builder
    import dsab_pkg::*;
#(
    parameter int MAX_LEN       = 1024,
    parameter int ALPHABET_SIZE = 5
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [1:0]  base,
    input  logic [9:0]  index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [10:0] value,
    output logic        error
);

    dsab_cmd_t    cmd;
    dsab_status_t st;

    dsab_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .st       (st),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    dsab_dp #(
        .MAX_LEN       (MAX_LEN),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .base      (base),
        .index     (index),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .value     (value),
        .error     (error)
    );

endmodule
